[rtl/cbc_pkg.sv]
// ----------------------------------------------------------------------------
// cbc_pkg
// Types and constants shared by the cartridge bank controller modules.
// ----------------------------------------------------------------------------
package cbc_pkg;

	typedef struct packed {
		logic        req_type;
		logic [15:0] bus_address;
		logic        ram_chip_select;
		logic [7:0]  write_byte;
	} cbc_in_t;

	typedef struct packed {
		logic       flash_enable;
		logic [7:0] flash_bank;
		logic       data_driven;
		logic [7:0] read_byte;
		logic       event_valid;
		logic [2:0] event_code;
		logic [7:0] event_byte;
		logic       rumble_level;
	} cbc_out_t;

	typedef struct packed {
		logic       en;
		logic       we;
		logic [7:0] wdata;
	} cbc_mem_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_WR2
	} cbc_state_t;

	localparam logic       REQ_READ  = 1'b0;
	localparam logic       REQ_WRITE = 1'b1;

	localparam logic [1:0] KIND_STANDARD = 2'd0;
	localparam logic [1:0] KIND_NIBBLE   = 2'd1;
	localparam logic [1:0] KIND_ACCEL    = 2'd2;

	localparam logic [2:0] CFG_KIND      = 3'd0;
	localparam logic [2:0] CFG_BATTERY   = 3'd1;
	localparam logic [2:0] CFG_CLOCK     = 3'd2;
	localparam logic [2:0] CFG_RUMBLE    = 3'd3;
	localparam logic [2:0] CFG_COMMAND   = 3'd4;
	localparam logic [2:0] CFG_ROM_MASK  = 3'd5;
	localparam logic [2:0] CFG_RAM_MASK  = 3'd6;

	localparam logic [2:0] EV_SAVE       = 3'd0;
	localparam logic [2:0] EV_LATCH      = 3'd1;
	localparam logic [2:0] EV_CLOCK_WR   = 3'd2;
	localparam logic [2:0] EV_ACCEL_WR   = 3'd3;
	localparam logic [2:0] EV_COMMAND    = 3'd4;

	localparam logic [2:0] REGION_RAM_EN   = 3'd0;
	localparam logic [2:0] REGION_ROM_BANK = 3'd1;
	localparam logic [2:0] REGION_RAM_BANK = 3'd2;
	localparam logic [2:0] REGION_COMMAND  = 3'd3;

	localparam logic [12:0] OFFSET_MASK_STD    = 13'h1FFF;
	localparam logic [12:0] OFFSET_MASK_NIBBLE = 13'h01FF;
	localparam logic [12:0] OFFSET_MASK_ACCEL  = 13'h10F0;
	localparam logic [3:0]  RAM_EN_KEY         = 4'hA;
	localparam logic [7:0]  NIBBLE_FILL        = 8'hF0;
	localparam logic [7:0]  LATCH_BYTE         = 8'h01;
	localparam logic [7:0]  CLOCK_FLAG_BYTE    = 8'h01;
	localparam logic [3:0]  CLOCK_FLAG_STEP    = 4'd8;
	localparam int          OFFSET_MAX         = 8191;
	localparam int          BANK_MAX           = 15;

endpackage

[rtl/cartridge_bank_controller_core.sv]
// ----------------------------------------------------------------------------
// cartridge_bank_controller_core
// Bank controller for a game cartridge: serves one console bus access per
// beat, keeps the bank registers and the cartridge RAM, and raises events.
// ----------------------------------------------------------------------------
// After reset the block clears the cartridge RAM, one byte per cycle, and
// no access is accepted during that pass, but configuration writes are.
// Afterward an access is taken into a holding register and executed in the
// next cycle. A RAM or clock register read passes through a further state,
// ST_READ, because the single RAM port returns its data registered, in the
// cycle after the address. A clock register write also passes through a
// further state, ST_WR2, because it writes two bytes through the same port.
// The result sits in an output register, and the next access is taken no
// earlier than the cycle in which that result is taken.
module cartridge_bank_controller_core import cbc_pkg::*; #(
	parameter int RAM_BANKS  = 16,
	parameter int BANK_BYTES = 8192,
	parameter int CLOCK_BANK = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  cbc_in_t    in_item,
	output logic       out_valid,
	input  logic       out_stall,
	output cbc_out_t   out_item,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	localparam int STORE_BYTES = RAM_BANKS * BANK_BYTES;
	localparam int IDX_W       = $clog2(STORE_BYTES);
	localparam int SUM_MAX     = BANK_MAX * BANK_BYTES + OFFSET_MAX;
	localparam int SUM_W       = $clog2(SUM_MAX + 1);
	localparam int QUOT_MAX    = SUM_MAX / STORE_BYTES;
	localparam int RED_STEPS   = (QUOT_MAX == 0) ? 0 : $clog2(QUOT_MAX + 1);
	localparam logic [3:0] CLOCK_BANK_ID = 4'(CLOCK_BANK);

	cbc_state_t state_q, state_nxt;

	logic [1:0] kind_q;
	logic       battery_q;
	logic       clock_present_q;
	logic       rumble_present_q;
	logic       command_q;
	logic [7:0] rom_mask_q;
	logic [3:0] ram_mask_q;

	logic [7:0] rom_bank_q, rom_bank_nxt;
	logic [3:0] ram_bank_q, ram_bank_nxt;
	logic       ram_open_q, ram_open_nxt;
	logic       clock_mapped_q, clock_mapped_nxt;
	logic [2:0] clock_reg_q, clock_reg_nxt;
	logic       rumble_q, rumble_nxt;

	cbc_in_t    item_s1;
	cbc_out_t   out_q;
	logic       out_valid_q;

	cbc_out_t     res;
	cbc_mem_ctl_t mem_ctl;
	logic         go_read;
	logic         go_wr2;
	logic [3:0]   sel_bank;
	logic [12:0]  sel_offset;
	logic [SUM_W-1:0] sum_idx;
	logic [SUM_W-1:0] red_idx;
	logic [IDX_W-1:0] mem_addr;
	logic [7:0]   mem_rdata;
	logic         store_busy;
	logic         in_accept;
	logic         out_load;

	logic         a15, a14;
	logic         is_kind1, is_kind2;
	logic         clock_act;
	logic [7:0]   rom_masked;

	assign in_stall  = !((state_q == ST_IDLE) && !store_busy
	                     && (!out_valid_q || !out_stall));
	assign in_accept = in_valid && !in_stall;

	assign a15        = item_s1.bus_address[15];
	assign a14        = item_s1.bus_address[14];
	assign is_kind1   = (kind_q == KIND_NIBBLE);
	assign is_kind2   = (kind_q == KIND_ACCEL);
	assign clock_act  = clock_present_q && clock_mapped_q && !is_kind1;
	assign rom_masked = item_s1.write_byte & rom_mask_q;

	// RAM byte index: bank and offset, wrapped to the store size.
	always_comb begin
		if (state_q == ST_WR2) begin
			sel_bank   = CLOCK_BANK_ID;
			sel_offset = 13'({1'b0, clock_reg_q} + CLOCK_FLAG_STEP);
		end else if (clock_act) begin
			sel_bank   = CLOCK_BANK_ID;
			sel_offset = 13'(clock_reg_q);
		end else if (is_kind1) begin
			sel_bank   = '0;
			sel_offset = item_s1.bus_address[12:0] & OFFSET_MASK_NIBBLE;
		end else if (is_kind2) begin
			sel_bank   = ram_bank_q;
			sel_offset = item_s1.bus_address[12:0] & OFFSET_MASK_ACCEL;
		end else begin
			sel_bank   = ram_bank_q;
			sel_offset = item_s1.bus_address[12:0] & OFFSET_MASK_STD;
		end
	end

	assign sum_idx = SUM_W'(sel_bank) * SUM_W'(BANK_BYTES) + SUM_W'(sel_offset);

	always_comb begin
		red_idx = sum_idx;
		for (int k = RED_STEPS - 1; k >= 0; k--) begin
			if (red_idx >= (SUM_W'(STORE_BYTES) << k)) begin
				red_idx = red_idx - (SUM_W'(STORE_BYTES) << k);
			end
		end
	end

	assign mem_addr = red_idx[IDX_W-1:0];

	// Decode of the held access.
	always_comb begin
		res              = '0;
		go_read          = 1'b0;
		go_wr2           = 1'b0;
		mem_ctl          = '0;
		rom_bank_nxt     = rom_bank_q;
		ram_bank_nxt     = ram_bank_q;
		ram_open_nxt     = ram_open_q;
		clock_mapped_nxt = clock_mapped_q;
		clock_reg_nxt    = clock_reg_q;
		rumble_nxt       = rumble_q;
		if (state_q == ST_WR2) begin
			mem_ctl.en    = 1'b1;
			mem_ctl.we    = 1'b1;
			mem_ctl.wdata = CLOCK_FLAG_BYTE;
		end else if (state_q == ST_EXEC) begin
			if (item_s1.req_type == REQ_READ) begin
				if (!a15) begin
					res.flash_enable = 1'b1;
					res.flash_bank   = a14 ? rom_bank_q : '0;
				end else if (ram_open_q && item_s1.ram_chip_select && !a14) begin
					go_read    = 1'b1;
					mem_ctl.en = 1'b1;
				end
			end else if (item_s1.ram_chip_select && !a14) begin
				if (ram_open_q) begin
					mem_ctl.en = 1'b1;
					mem_ctl.we = 1'b1;
					if (clock_act) begin
						mem_ctl.wdata   = item_s1.write_byte;
						go_wr2          = 1'b1;
						res.event_valid = 1'b1;
						res.event_code  = EV_CLOCK_WR;
					end else begin
						mem_ctl.wdata = is_kind1 ? (item_s1.write_byte | NIBBLE_FILL)
						                         : item_s1.write_byte;
						if (is_kind2) begin
							res.event_valid = 1'b1;
							res.event_code  = EV_ACCEL_WR;
						end else if (battery_q) begin
							res.event_valid = 1'b1;
							res.event_code  = EV_SAVE;
						end
					end
				end
			end else if (is_kind1) begin
				if (!a15 && !a14) begin
					if (item_s1.bus_address[8]) begin
						rom_bank_nxt = (rom_masked == '0) ? 8'd1 : rom_masked;
					end else begin
						ram_open_nxt = (item_s1.write_byte[3:0] == RAM_EN_KEY);
					end
				end
			end else begin
				case (item_s1.bus_address[15:13])
					REGION_RAM_EN: begin
						ram_open_nxt = (item_s1.write_byte[3:0] == RAM_EN_KEY);
					end
					REGION_ROM_BANK: begin
						rom_bank_nxt = rom_masked;
					end
					REGION_RAM_BANK: begin
						ram_bank_nxt     = item_s1.write_byte[3:0] & ram_mask_q;
						clock_mapped_nxt = item_s1.write_byte[3];
						clock_reg_nxt    = item_s1.write_byte[2:0];
						if (rumble_present_q) begin
							rumble_nxt = item_s1.write_byte[3];
						end
					end
					REGION_COMMAND: begin
						if (command_q) begin
							res.event_valid = 1'b1;
							res.event_code  = EV_COMMAND;
							res.event_byte  = item_s1.write_byte;
						end else if (clock_present_q && item_s1.write_byte == LATCH_BYTE) begin
							res.event_valid = 1'b1;
							res.event_code  = EV_LATCH;
						end
					end
					default: begin
					end
				endcase
			end
		end else if (state_q == ST_READ) begin
			res.data_driven = 1'b1;
			res.read_byte   = mem_rdata;
		end
		res.rumble_level = rumble_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (go_read) begin
					state_nxt = ST_READ;
				end else if (go_wr2) begin
					state_nxt = ST_WR2;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_READ: state_nxt = ST_IDLE;
			ST_WR2:  state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	assign out_load = ((state_q == ST_EXEC) && !go_read) || (state_q == ST_READ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			out_valid_q      <= 1'b0;
			kind_q           <= KIND_STANDARD;
			battery_q        <= 1'b0;
			clock_present_q  <= 1'b0;
			rumble_present_q <= 1'b0;
			command_q        <= 1'b0;
			rom_mask_q       <= 8'hFF;
			ram_mask_q       <= 4'hF;
			rom_bank_q       <= 8'd1;
			ram_bank_q       <= '0;
			ram_open_q       <= 1'b0;
			clock_mapped_q   <= 1'b0;
			clock_reg_q      <= '0;
			rumble_q         <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_KIND:     kind_q           <= cfg_data[1:0];
					CFG_BATTERY:  battery_q        <= cfg_data[0];
					CFG_CLOCK:    clock_present_q  <= cfg_data[0];
					CFG_RUMBLE:   rumble_present_q <= cfg_data[0];
					CFG_COMMAND:  command_q        <= cfg_data[0];
					CFG_ROM_MASK: rom_mask_q       <= cfg_data;
					CFG_RAM_MASK: ram_mask_q       <= cfg_data[3:0];
					default: begin
					end
				endcase
			end
			if (state_q == ST_EXEC) begin
				rom_bank_q     <= rom_bank_nxt;
				ram_bank_q     <= ram_bank_nxt;
				ram_open_q     <= ram_open_nxt;
				clock_mapped_q <= clock_mapped_nxt;
				clock_reg_q    <= clock_reg_nxt;
				rumble_q       <= rumble_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= in_item;
		end
		if (out_load) begin
			out_q <= res;
		end
	end

	cbc_store #(
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mem_ctl),
		.addr  (mem_addr),
		.rdata (mem_rdata),
		.busy  (store_busy)
	);

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_exec_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC || state_q == ST_READ) |-> !out_valid_q)
		else $error("Result loaded while the output register is still full.");

	a_wr2_follows_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR2) |-> ($past(state_q) == ST_EXEC) && out_valid_q
		&& out_q.event_valid && out_q.event_code == EV_CLOCK_WR)
		else $error("Second clock write without a clock write result.");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> out_valid_q && out_q.data_driven && !out_q.flash_enable)
		else $error("RAM read did not deliver driven data.");

	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		store_busy |-> in_stall && (state_q == ST_IDLE))
		else $error("Access taken during the RAM clearing pass.");

	a_event_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.event_valid) |-> out_q.event_code == EV_SAVE
		&& out_q.event_byte == '0)
		else $error("Event fields set without an event.");

endmodule

[rtl/cbc_store.sv]
// ----------------------------------------------------------------------------
// cbc_store
// Single-port cartridge RAM with registered read data and a clearing pass
// that zeroes every byte after reset.
// ----------------------------------------------------------------------------
module cbc_store import cbc_pkg::*; #(
	parameter int DEPTH = 131072
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cbc_mem_ctl_t             ctl,
	input  logic [$clog2(DEPTH)-1:0] addr,
	output logic [7:0]               rdata,
	output logic                     busy
);

	localparam int AW = $clog2(DEPTH);

	logic [7:0]    mem [DEPTH];
	logic [AW-1:0] clr_idx_q;
	logic          clearing_q;
	logic [7:0]    rdata_q;
	logic [AW-1:0] mem_addr;
	logic          mem_we;
	logic [7:0]    mem_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			if (clr_idx_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	always_comb begin
		if (clearing_q) begin
			mem_addr  = clr_idx_q;
			mem_we    = 1'b1;
			mem_wdata = '0;
		end else begin
			mem_addr  = addr;
			mem_we    = ctl.en & ctl.we;
			mem_wdata = ctl.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (!clearing_q && ctl.en && !ctl.we) begin
			rdata_q <= mem[mem_addr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = clearing_q;

endmodule
